// ===== design/kpe_pkg.sv =====
// Shared constants, codes and types of the keypad layer press encoder.
// No dependencies; every other design file except kpe_ram imports this package.
package kpe_pkg;

    localparam int NUM_PRESETS  = 4;
    localparam int NUM_KEYS     = 16;
    localparam int TABLE_DEPTH  = NUM_PRESETS * NUM_KEYS;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int MATRIX_KEYS  = 16;

    localparam int KIND_W   = 2;
    localparam int ROW0_W   = 6;
    localparam int ROW_W    = 4;
    localparam int IDX_W    = 6;
    localparam int CODE_W   = 8;
    localparam int LEN_W    = 3;
    localparam int MOD_W    = 8;
    localparam int EV_W     = 2;
    localparam int KEY_W    = 4;
    localparam int PRESET_W = 2;
    localparam int LED_W    = 8;
    localparam int TICK_W   = 16;

    localparam int PRESET_UP_BIT   = 4;
    localparam int PRESET_DOWN_BIT = 5;

    localparam logic [TICK_W-1:0] IDLE_LIMIT_RST = TICK_W'(61 * 8);
    localparam logic [CODE_W-1:0] SPACE_CODE     = CODE_W'(44);
    localparam logic [LEN_W-1:0]  SPACE_LEN      = LEN_W'(1);
    localparam logic [LED_W-1:0]  LED_MSB        = LED_W'(1) << (LED_W - 1);

    localparam int Q_DEPTH = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_SCAN  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [EV_W-1:0] {
        EV_PRESS  = 2'd0,
        EV_STATUS = 2'd1,
        EV_IDLE   = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        OP_SCAN   = 2'd0,
        OP_STATUS = 2'd1,
        OP_IDLE   = 2'd2,
        OP_WRITE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [MOD_W-1:0]  modifier;
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] key;
    } t_entry;

    typedef struct packed {
        t_op                    op;
        logic [MATRIX_KEYS-1:0] mask;
        logic [PRESET_W-1:0]    preset_old;
        logic [PRESET_W-1:0]    preset_new;
        logic [ADDR_W-1:0]      wr_addr;
        t_entry                 wr_data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

// ===== design/kpe_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on kpe_pkg for field widths.
interface kpe_in_if import kpe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ROW0_W-1:0]   row0_bits;
    logic [ROW_W-1:0]    row1_bits;
    logic [ROW_W-1:0]    row2_bits;
    logic [ROW_W-1:0]    row3_bits;
    logic [IDX_W-1:0]    entry_index;
    logic [CODE_W-1:0]   entry_key;
    logic [LEN_W-1:0]    entry_length;
    logic [MOD_W-1:0]    entry_modifier;

    modport source (
        output valid, kind, row0_bits, row1_bits, row2_bits, row3_bits,
               entry_index, entry_key, entry_length, entry_modifier,
        input  ready
    );
    modport sink (
        input  valid, kind, row0_bits, row1_bits, row2_bits, row3_bits,
               entry_index, entry_key, entry_length, entry_modifier,
        output ready
    );
endinterface

interface kpe_out_if import kpe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [EV_W-1:0]     event_res;
    logic [CODE_W-1:0]   key_code;
    logic [LEN_W-1:0]    key_length;
    logic [MOD_W-1:0]    modifier;
    logic [KEY_W-1:0]    key_number;
    logic [PRESET_W-1:0] preset;
    logic [LED_W-1:0]    preset_led;
    logic                last;

    modport source (
        output valid, event_res, key_code, key_length, modifier, key_number,
               preset, preset_led, last,
        input  ready
    );
    modport sink (
        input  valid, event_res, key_code, key_length, modifier, key_number,
               preset, preset_led, last,
        output ready
    );
endinterface

// ===== design/keypad_layer_press_encoder_unit.sv =====
// An accepted item passes through the command queue, the command register, the table-read
// stage and the output register. A scan with n new key presses loads its command, reads the
// table once per press and ends with one status; tick and table write give one result each.
// A two-entry command queue lets the front accept while the back drains results.
// Reset clears matrix history, preset, idle counter and sets idle_limit to 488;
// the key table is not cleared and must be written before it is read.
module keypad_layer_press_encoder_unit import kpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kpe_in_if.sink            i_in,
    kpe_out_if.source         o_out,
    input  logic              i_cfg_wr_en,
    input  logic [TICK_W-1:0] i_cfg_wr_data
);
    logic    q_push;
    t_cmd    q_cmd_in;
    logic    q_pop;
    t_cmd    q_cmd_out;
    t_q_stat q_stat;

    kpe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_stat      (q_stat),
        .o_q_push      (q_push),
        .o_q_cmd       (q_cmd_in)
    );

    kpe_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd_in),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd_out),
        .o_stat  (q_stat)
    );

    kpe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_q_cmd  (q_cmd_out),
        .o_q_pop  (q_pop),
        .o_out    (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_accept_reaches_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> q_stat.valid)
        else $error("accepted item missing from command queue");

    a_led_tracks_preset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.preset_led == (LED_MSB >> o_out.preset)))
        else $error("preset LED does not match preset");
endmodule

// ===== design/kpe_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== design/kpe_front.sv =====
// Front end: accepts input items, tracks matrix, preset and idle state,
// and turns each item into a command for the back end. Uses kpe_pkg, kpe_if.
module kpe_front import kpe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    kpe_in_if.sink               i_in,
    input  logic                 i_cfg_wr_en,
    input  logic [TICK_W-1:0]    i_cfg_wr_data,
    input  t_q_stat              i_q_stat,
    output logic                 o_q_push,
    output t_cmd                 o_q_cmd
);
    logic [TICK_W-1:0]      r_idle_limit;
    logic [ROW0_W-1:0]      r_prev_row0;
    logic [ROW_W-1:0]       r_prev_row1;
    logic [ROW_W-1:0]       r_prev_row2;
    logic [ROW_W-1:0]       r_prev_row3;
    logic [PRESET_W-1:0]    r_preset;
    logic [TICK_W-1:0]      r_idle_ticks;

    logic [PRESET_W-1:0]    n_preset;
    logic [TICK_W-1:0]      n_idle_ticks;
    logic                   n_scan;

    logic                   accept;
    logic [ROW0_W-1:0]      rise0;
    logic [ROW_W-1:0]       rise1;
    logic [ROW_W-1:0]       rise2;
    logic [ROW_W-1:0]       rise3;
    logic [MATRIX_KEYS-1:0] key_ok;
    logic [PRESET_W-1:0]    preset_dn;
    logic [PRESET_W-1:0]    preset_up;
    logic [TICK_W-1:0]      ticks_inc;
    logic                   pressed;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_q_push   = accept;

    assign rise0 = i_in.row0_bits & ~r_prev_row0;
    assign rise1 = i_in.row1_bits & ~r_prev_row1;
    assign rise2 = i_in.row2_bits & ~r_prev_row2;
    assign rise3 = i_in.row3_bits & ~r_prev_row3;
    assign pressed = (|rise0) || (|rise1) || (|rise2) || (|rise3);
    assign ticks_inc = r_idle_ticks + TICK_W'(1);

    // down is applied first, then up, both with wrap
    always_comb begin
        if (!rise0[PRESET_DOWN_BIT]) begin
            preset_dn = r_preset;
        end else if (r_preset == '0) begin
            preset_dn = PRESET_W'(NUM_PRESETS - 1);
        end else begin
            preset_dn = r_preset - PRESET_W'(1);
        end
        if (!rise0[PRESET_UP_BIT]) begin
            preset_up = preset_dn;
        end else if (preset_dn >= PRESET_W'(NUM_PRESETS - 1)) begin
            preset_up = '0;
        end else begin
            preset_up = preset_dn + PRESET_W'(1);
        end
    end

    always_comb begin
        for (int k = 0; k < MATRIX_KEYS; k++) begin
            key_ok[k] = (k < NUM_KEYS);
        end
        o_q_cmd.op               = OP_STATUS;
        o_q_cmd.mask             = '0;
        o_q_cmd.preset_old       = r_preset;
        o_q_cmd.preset_new       = r_preset;
        o_q_cmd.wr_addr          = ADDR_W'(i_in.entry_index);
        o_q_cmd.wr_data.modifier = i_in.entry_modifier;
        o_q_cmd.wr_data.length   = i_in.entry_length;
        o_q_cmd.wr_data.key      = i_in.entry_key;
        n_preset                 = r_preset;
        n_idle_ticks             = r_idle_ticks;
        n_scan                   = 1'b0;
        unique case (t_kind'(i_in.kind))
            KIND_SCAN: begin
                n_scan             = 1'b1;
                o_q_cmd.op         = OP_SCAN;
                o_q_cmd.mask       = {rise3, rise2, rise1, rise0[ROW_W-1:0]} & key_ok;
                o_q_cmd.preset_new = preset_up;
                n_preset           = preset_up;
                if (pressed) begin
                    n_idle_ticks = '0;
                end
            end
            KIND_TICK: begin
                if (ticks_inc > r_idle_limit) begin
                    o_q_cmd.op   = OP_IDLE;
                    n_idle_ticks = '0;
                end else begin
                    n_idle_ticks = ticks_inc;
                end
            end
            KIND_WRITE: begin
                if ({1'b0, i_in.entry_index} < (IDX_W + 1)'(TABLE_DEPTH)) begin
                    o_q_cmd.op = OP_WRITE;
                end
            end
            KIND_NONE: begin
                o_q_cmd.op = OP_STATUS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= IDLE_LIMIT_RST;
            r_prev_row0  <= '0;
            r_prev_row1  <= '0;
            r_prev_row2  <= '0;
            r_prev_row3  <= '0;
            r_preset     <= '0;
            r_idle_ticks <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_idle_limit <= i_cfg_wr_data;
            end
            if (accept) begin
                r_preset     <= n_preset;
                r_idle_ticks <= n_idle_ticks;
                if (n_scan) begin
                    r_prev_row0 <= i_in.row0_bits;
                    r_prev_row1 <= i_in.row1_bits;
                    r_prev_row2 <= i_in.row2_bits;
                    r_prev_row3 <= i_in.row3_bits;
                end
            end
        end
    end
endmodule

// ===== design/kpe_cmd_q.sv =====
// Short command queue between front end and back end.
// Uses kpe_pkg.
module kpe_cmd_q import kpe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);
    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_slot [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_cmd        = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_stat.valid = (r_count != '0);

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end
endmodule

// ===== design/kpe_back.sv =====
// Back end: walks each command, reads the key table, and serializes results
// through a table-read stage and an output register. Uses kpe_pkg, kpe_if, kpe_ram.
module kpe_back import kpe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_q_stat,
    input  t_cmd    i_q_cmd,
    output logic    o_q_pop,
    kpe_out_if.source o_out
);
    typedef struct packed {
        t_event              ev;
        logic [KEY_W-1:0]    key;
        logic [PRESET_W-1:0] preset;
        logic                last;
    } t_meta;

    logic                   r_busy;
    t_cmd                   r_cmd;
    logic [MATRIX_KEYS-1:0] r_mask;
    logic                   r_s1_valid;
    t_meta                  r_s1;
    logic                   r_o_valid;
    logic [EV_W-1:0]        r_o_event;
    logic [CODE_W-1:0]      r_o_code;
    logic [LEN_W-1:0]       r_o_len;
    logic [MOD_W-1:0]       r_o_mod;
    logic [KEY_W-1:0]       r_o_key;
    logic [PRESET_W-1:0]    r_o_preset;
    logic [LED_W-1:0]       r_o_led;
    logic                   r_o_last;

    logic [MATRIX_KEYS-1:0] n_mask;
    logic [CODE_W-1:0]      n_code;
    logic [LEN_W-1:0]       n_len;
    logic [MOD_W-1:0]       n_mod;

    logic                   out_free;
    logic                   s1_adv;
    logic                   issue_ok;
    logic                   has_key;
    logic [KEY_W-1:0]       first_key;
    t_meta                  iss;
    logic                   iss_done;
    logic                   wr_en;
    logic [ADDR_W-1:0]      rd_addr;
    t_entry                 rd_entry;

    assign out_free = !r_o_valid || o_out.ready;
    assign s1_adv   = !r_s1_valid || out_free;
    assign issue_ok = r_busy && s1_adv;
    assign o_q_pop  = !r_busy && i_q_stat.valid;
    assign has_key  = |r_mask;
    assign wr_en    = issue_ok && (r_cmd.op == OP_WRITE);
    assign rd_addr  = ADDR_W'(r_cmd.preset_old) * ADDR_W'(NUM_KEYS) + ADDR_W'(first_key);
    assign n_mask   = r_mask & ~(MATRIX_KEYS'(1) << first_key);

    // lowest pending key first
    always_comb begin
        first_key = '0;
        for (int k = MATRIX_KEYS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                first_key = KEY_W'(k);
            end
        end
    end

    always_comb begin
        iss.ev     = EV_STATUS;
        iss.key    = '0;
        iss.preset = r_cmd.preset_new;
        iss.last   = 1'b1;
        iss_done   = 1'b1;
        unique case (r_cmd.op)
            OP_SCAN: begin
                if (has_key) begin
                    iss.ev     = EV_PRESS;
                    iss.key    = first_key;
                    iss.preset = r_cmd.preset_old;
                    iss.last   = 1'b0;
                    iss_done   = 1'b0;
                end
            end
            OP_IDLE: begin
                iss.ev = EV_IDLE;
            end
            OP_STATUS, OP_WRITE: begin
                iss.ev = EV_STATUS;
            end
        endcase
    end

    kpe_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cmd.wr_addr),
        .i_wr_data (r_cmd.wr_data),
        .i_rd_en   (issue_ok),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_entry)
    );

    always_comb begin
        unique case (r_s1.ev)
            EV_PRESS: begin
                n_code = rd_entry.key;
                n_len  = rd_entry.length;
                n_mod  = rd_entry.modifier;
            end
            EV_IDLE: begin
                n_code = SPACE_CODE;
                n_len  = SPACE_LEN;
                n_mod  = '0;
            end
            default: begin
                n_code = '0;
                n_len  = '0;
                n_mod  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd  <= i_q_cmd;
            r_mask <= i_q_cmd.mask;
        end else if (issue_ok) begin
            r_mask <= n_mask;
        end
        if (s1_adv) begin
            r_s1 <= iss;
        end
        if (out_free) begin
            r_o_event  <= r_s1.ev;
            r_o_code   <= n_code;
            r_o_len    <= n_len;
            r_o_mod    <= n_mod;
            r_o_key    <= r_s1.key;
            r_o_preset <= r_s1.preset;
            r_o_led    <= LED_MSB >> r_s1.preset;
            r_o_last   <= r_s1.last;
        end
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end else if (issue_ok && iss_done) begin
                r_busy <= 1'b0;
            end
            if (s1_adv) begin
                r_s1_valid <= r_busy;
            end
            if (out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.event_res  = r_o_event;
    assign o_out.key_code   = r_o_code;
    assign o_out.key_length = r_o_len;
    assign o_out.modifier   = r_o_mod;
    assign o_out.key_number = r_o_key;
    assign o_out.preset     = r_o_preset;
    assign o_out.preset_led = r_o_led;
    assign o_out.last       = r_o_last;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for keypad_layer_press_encoder_unit: scans, ticks and table writes.
// Results are checked against an in-bench encoder model; depends on kpe_pkg and kpe_if.
module tb;
    import kpe_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int N_DIR       = 27;
    localparam int N_PHASES    = 5;
    localparam int PHASE_ITEMS = 44;

    typedef struct packed {
        t_kind               kind;
        logic [ROW0_W-1:0]   row0;
        logic [ROW_W-1:0]    row1;
        logic [ROW_W-1:0]    row2;
        logic [ROW_W-1:0]    row3;
        logic [IDX_W-1:0]    index;
        logic [CODE_W-1:0]   key;
        logic [LEN_W-1:0]    len;
        logic [MOD_W-1:0]    modi;
    } t_item;

    typedef struct packed {
        t_event              ev;
        logic [CODE_W-1:0]   code;
        logic [LEN_W-1:0]    len;
        logic [MOD_W-1:0]    modi;
        logic [KEY_W-1:0]    num;
        logic [PRESET_W-1:0] preset;
        logic [LED_W-1:0]    led;
        logic                last;
    } t_report;

    // Either an idle_limit write or one item; typed rows carry the final result.
    typedef struct packed {
        bit                  is_cfg;
        logic [TICK_W-1:0]   cfg_val;
        t_item               it;
        bit                  typed;
        t_event              tev;
        logic [PRESET_W-1:0] tp;
    } t_row;

    localparam t_item NO_ITEM = '{KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0};

    t_row dir_tab [N_DIR] = '{
        '{0, 0, '{KIND_NONE, 6'h3F, 4'hF, 4'hF, 4'hF, 6'h3F, 8'hFF, 3'h7, 8'hFF}, 1, EV_STATUS, 0},
        '{0, 0, '{KIND_TICK, 6'h00, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 0},
        '{0, 0, '{KIND_WRITE, 6'h00, 4'h0, 4'h0, 4'h0, 6'h00, 8'hFF, 3'h7, 8'hFF}, 1, EV_STATUS, 0},
        '{0, 0, '{KIND_WRITE, 6'h00, 4'h0, 4'h0, 4'h0, 6'h3F, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 0},
        '{0, 0, '{KIND_WRITE, 6'h00, 4'h0, 4'h0, 4'h0, 6'h0F, 8'h04, 3'h6, 8'h01}, 1, EV_STATUS, 0},
        '{0, 0, '{KIND_SCAN, 6'h0F, 4'hF, 4'hF, 4'hF, 6'h00, 8'h00, 3'h0, 8'h00}, 0, EV_STATUS, 0},
        '{0, 0, '{KIND_SCAN, 6'h00, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 0},
        '{0, 0, '{KIND_SCAN, 6'h20, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 3},
        '{0, 0, '{KIND_SCAN, 6'h00, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 3},
        '{0, 0, '{KIND_SCAN, 6'h10, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 0},
        '{0, 0, '{KIND_SCAN, 6'h00, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 0},
        '{0, 0, '{KIND_SCAN, 6'h30, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 0},
        '{0, 0, '{KIND_SCAN, 6'h00, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 0},
        '{0, 0, '{KIND_SCAN, 6'h10, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 1},
        '{0, 0, '{KIND_SCAN, 6'h00, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 1},
        '{0, 0, '{KIND_SCAN, 6'h10, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 2},
        '{0, 0, '{KIND_SCAN, 6'h00, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 2},
        '{0, 0, '{KIND_SCAN, 6'h10, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 3},
        '{0, 0, '{KIND_SCAN, 6'h3F, 4'hF, 4'hF, 4'hF, 6'h00, 8'h00, 3'h0, 8'h00}, 0, EV_STATUS, 2},
        '{1, 16'd0, NO_ITEM, 0, EV_STATUS, 0},
        '{0, 0, '{KIND_TICK, 6'h00, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_IDLE, 2},
        '{0, 0, '{KIND_TICK, 6'h3F, 4'hF, 4'hF, 4'hF, 6'h3F, 8'hFF, 3'h7, 8'hFF}, 1, EV_IDLE, 2},
        '{1, 16'hFFFF, NO_ITEM, 0, EV_STATUS, 0},
        '{0, 0, '{KIND_TICK, 6'h00, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 2},
        '{1, IDLE_LIMIT_RST, NO_ITEM, 0, EV_STATUS, 0},
        '{0, 0, '{KIND_SCAN, 6'h00, 4'h0, 4'h0, 4'h0, 6'h00, 8'h00, 3'h0, 8'h00}, 1, EV_STATUS, 2},
        '{0, 0, '{KIND_SCAN, 6'h01, 4'h0, 4'h0, 4'h8, 6'h00, 8'h00, 3'h0, 8'h00}, 0, EV_STATUS, 2}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [TICK_W-1:0] i_cfg_wr_data;

    kpe_in_if  in_ch ();
    kpe_out_if out_ch ();

    keypad_layer_press_encoder_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #2 i_clk = ~i_clk;

    // encoder model state
    logic [TICK_W-1:0]   idle_lim   = IDLE_LIMIT_RST;
    logic [TICK_W-1:0]   idle_cnt   = '0;
    logic [PRESET_W-1:0] cur_preset = '0;
    logic [ROW0_W-1:0]   prev_row0  = '0;
    logic [ROW_W-1:0]    prev_rows [3] = '{default: '0};
    t_entry              key_tab [TABLE_DEPTH];

    t_report report_q [$];
    int      errors        = 0;
    bit      steady        = 1'b0;
    int      hold_req_cnt  = 0;

    task automatic report_error(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void push_report(input t_event ev, input logic [CODE_W-1:0] code,
                                        input logic [LEN_W-1:0] len,
                                        input logic [MOD_W-1:0] modi,
                                        input logic [KEY_W-1:0] num, input logic last);
        t_report r;
        r.ev     = ev;
        r.code   = code;
        r.len    = len;
        r.modi   = modi;
        r.num    = num;
        r.preset = cur_preset;
        r.led    = LED_MSB >> cur_preset;
        r.last   = last;
        report_q.push_back(r);
    endfunction

    function automatic void encode_item(input t_item it);
        logic [MATRIX_KEYS-1:0] now_keys;
        logic [MATRIX_KEYS-1:0] was_keys;
        logic [MATRIX_KEYS-1:0] rise;
        logic                   down;
        logic                   up;
        t_entry                 ent;
        case (it.kind)
            KIND_SCAN: begin
                now_keys = {it.row3, it.row2, it.row1, it.row0[3:0]};
                was_keys = {prev_rows[2], prev_rows[1], prev_rows[0], prev_row0[3:0]};
                rise     = now_keys & ~was_keys;
                // key reports carry the preset in force before the preset buttons act
                for (int k = 0; k < MATRIX_KEYS; k++) begin
                    if (rise[k] && k < NUM_KEYS) begin
                        ent = key_tab[int'(cur_preset) * NUM_KEYS + k];
                        push_report(EV_PRESS, ent.key, ent.length, ent.modifier,
                                    KEY_W'(k), 1'b0);
                    end
                end
                down = it.row0[PRESET_DOWN_BIT] & ~prev_row0[PRESET_DOWN_BIT];
                up   = it.row0[PRESET_UP_BIT] & ~prev_row0[PRESET_UP_BIT];
                if (down)
                    cur_preset = (cur_preset == 0) ? PRESET_W'(NUM_PRESETS - 1)
                                                   : cur_preset - 1'b1;
                if (up)
                    cur_preset = (int'(cur_preset) >= NUM_PRESETS - 1) ? '0
                                                                       : cur_preset + 1'b1;
                if (|rise || down || up) idle_cnt = '0;
                prev_row0    = it.row0;
                prev_rows[0] = it.row1;
                prev_rows[1] = it.row2;
                prev_rows[2] = it.row3;
                push_report(EV_STATUS, '0, '0, '0, '0, 1'b1);
            end
            KIND_TICK: begin
                idle_cnt = idle_cnt + 1'b1;
                if (idle_cnt > idle_lim) begin
                    idle_cnt = '0;
                    push_report(EV_IDLE, SPACE_CODE, SPACE_LEN, '0, '0, 1'b1);
                end else begin
                    push_report(EV_STATUS, '0, '0, '0, '0, 1'b1);
                end
            end
            KIND_WRITE: begin
                if (int'(it.index) < TABLE_DEPTH) key_tab[it.index] = '{it.modi, it.len, it.key};
                push_report(EV_STATUS, '0, '0, '0, '0, 1'b1);
            end
            default: begin
                push_report(EV_STATUS, '0, '0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    sel;
        int    mode;
        sel  = $urandom_range(99);
        mode = $urandom_range(2);
        it.row0  = ROW0_W'($urandom);
        it.row1  = ROW_W'($urandom);
        it.row2  = ROW_W'($urandom);
        it.row3  = ROW_W'($urandom);
        it.index = IDX_W'($urandom);
        it.key   = CODE_W'($urandom);
        it.len   = LEN_W'($urandom);
        it.modi  = MOD_W'($urandom);
        if (sel < 45) begin
            it.kind = KIND_SCAN;
            if (mode == 0) begin
                // full release, so the next scan sees fresh edges
                it.row0 = '0;
                it.row1 = '0;
                it.row2 = '0;
                it.row3 = '0;
            end else if (mode == 1) begin
                it.row0 = it.row0 & ROW0_W'($urandom);
                it.row1 = it.row1 & ROW_W'($urandom);
                it.row2 = it.row2 & ROW_W'($urandom);
                it.row3 = it.row3 & ROW_W'($urandom);
            end
        end else if (sel < 80) begin
            it.kind = KIND_TICK;
        end else if (sel < 95) begin
            it.kind = KIND_WRITE;
        end else begin
            it.kind = KIND_NONE;
        end
        return it;
    endfunction

    // Offer one item until it transfers, then maybe leave a gap.
    task automatic send_item(input t_item it, input bit typed, input t_report typed_res);
        in_ch.valid          <= 1'b1;
        in_ch.kind           <= it.kind;
        in_ch.row0_bits      <= it.row0;
        in_ch.row1_bits      <= it.row1;
        in_ch.row2_bits      <= it.row2;
        in_ch.row3_bits      <= it.row3;
        in_ch.entry_index    <= it.index;
        in_ch.entry_key      <= it.key;
        in_ch.entry_length   <= it.len;
        in_ch.entry_modifier <= it.modi;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        encode_item(it);
        if (typed) report_q[report_q.size() - 1] = typed_res;
        if (!steady && $urandom_range(99) < 14) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Only written with the block drained.
    task automatic write_idle_limit(input logic [TICK_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        idle_lim = value;
    endtask

    task automatic check_output();
        t_report got;
        t_report want;
        got.ev     = t_event'(out_ch.event_res);
        got.code   = out_ch.key_code;
        got.len    = out_ch.key_length;
        got.modi   = out_ch.modifier;
        got.num    = out_ch.key_number;
        got.preset = out_ch.preset;
        got.led    = out_ch.preset_led;
        got.last   = out_ch.last;
        if (report_q.size() == 0) begin
            report_error("result transfer with nothing pending");
            return;
        end
        want = report_q.pop_front();
        if (got.ev !== want.ev)
            report_error($sformatf("event_res got %0d want %0d", got.ev, want.ev));
        if (got.code !== want.code)
            report_error($sformatf("key_code got %0h want %0h", got.code, want.code));
        if (got.len !== want.len)
            report_error($sformatf("key_length got %0d want %0d", got.len, want.len));
        if (got.modi !== want.modi)
            report_error($sformatf("modifier got %0h want %0h", got.modi, want.modi));
        if (got.num !== want.num)
            report_error($sformatf("key_number got %0d want %0d", got.num, want.num));
        if (got.preset !== want.preset)
            report_error($sformatf("preset got %0d want %0d", got.preset, want.preset));
        if (got.led !== want.led)
            report_error($sformatf("preset_led got %0h want %0h", got.led, want.led));
        if (got.last !== want.last)
            report_error($sformatf("last got %0b want %0b", got.last, want.last));
    endtask

    // result side: random backpressure plus a long hold-off on request
    initial begin
        int hold_left;
        int hold_done;
        hold_left = 0;
        hold_done = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_output();
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_req_cnt > hold_done) begin
                hold_done++;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= steady || ($urandom_range(99) >= 14);
            end
        end
    end

    // watchdog: cycles without any transfer on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_item       it;
        t_report     tr;
        t_row        row;
        logic [TICK_W-1:0] lim;
        i_rst_n              <= 1'b0;
        i_cfg_wr_en          <= 1'b0;
        i_cfg_wr_data        <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.kind           <= KIND_NONE;
        in_ch.row0_bits      <= '0;
        in_ch.row1_bits      <= '0;
        in_ch.row2_bits      <= '0;
        in_ch.row3_bits      <= '0;
        in_ch.entry_index    <= '0;
        in_ch.entry_key      <= '0;
        in_ch.entry_length   <= '0;
        in_ch.entry_modifier <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every table entry is written before any scan can read it
        for (int e = 0; e < TABLE_DEPTH; e++) begin
            it       = rand_item();
            it.kind  = KIND_WRITE;
            it.index = IDX_W'(e);
            send_item(it, 1'b0, '0);
        end

        for (int i = 0; i < N_DIR; i++) begin
            row = dir_tab[i];
            if (row.is_cfg) begin
                write_idle_limit(row.cfg_val);
            end else begin
                tr.ev     = row.tev;
                tr.code   = (row.tev == EV_IDLE) ? SPACE_CODE : '0;
                tr.len    = (row.tev == EV_IDLE) ? SPACE_LEN : '0;
                tr.modi   = '0;
                tr.num    = '0;
                tr.preset = row.tp;
                tr.led    = LED_MSB >> row.tp;
                tr.last   = 1'b1;
                send_item(row.it, row.typed, tr);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       lim = TICK_W'($urandom_range(0, 3));
                1:       lim = TICK_W'($urandom_range(4, 12));
                2:       lim = '0;
                3:       lim = TICK_W'($urandom_range(0, 65535));
                default: lim = '1;
            endcase
            write_idle_limit(lim);
            steady = (ph == 2);
            if (ph == 3) hold_req_cnt++;
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item(), 1'b0, '0);
        end

        in_ch.valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
